FILE: hw/rtl/cprc_pkg.sv
package cprc_pkg;

   localparam int unsigned MAX_CLAUSES_DEF  = 256;
   localparam int unsigned MAX_LITERALS_DEF = 32;
   localparam int unsigned LITERAL_BITS_DEF = 20;

   localparam int unsigned INDEX_BITS  = 8;
   localparam int unsigned STATUS_BITS = 3;
   localparam int unsigned MERGE_BITS  = 6;
   localparam int unsigned COUNT_BITS  = 9;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_CLOSE,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK,
      ST_FULL,
      ST_TOO_LONG,
      ST_BAD_INDEX,
      ST_BAD_LITERAL
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LITERAL,
      CMD_LENGTH,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      status_type              status;
      logic [INDEX_BITS-1:0]   first;
      logic [INDEX_BITS-1:0]   second;
      logic [COUNT_BITS-1:0]   count;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LENGTH,
      BK_PRIME,
      BK_STEP,
      BK_DONE
   } back_state_type;

   typedef enum logic {
      PH_RESOLVE,
      PH_MERGE
   } phase_type;

endpackage

FILE: hw/rtl/cprc_queue.sv
module cprc_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import cprc_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/cprc_front.sv
module cprc_front #(
   parameter int unsigned MAX_CLAUSES  = cprc_pkg::MAX_CLAUSES_DEF,
   parameter int unsigned MAX_LITERALS = cprc_pkg::MAX_LITERALS_DEF,
   parameter int unsigned LITERAL_BITS = cprc_pkg::LITERAL_BITS_DEF,
   parameter int unsigned CW = $clog2(MAX_CLAUSES),
   parameter int unsigned LW = $clog2(MAX_LITERALS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_op,
   input  logic signed [LITERAL_BITS-1:0]    req_literal,
   input  logic [cprc_pkg::INDEX_BITS-1:0]   req_first_clause,
   input  logic [cprc_pkg::INDEX_BITS-1:0]   req_second_clause,
   input  logic                              q_ready,
   output logic                              q_push,
   output cprc_pkg::cmd_type                 cmd,
   output logic [CW-1:0]                     cmd_clause,
   output logic [LW-1:0]                     cmd_pos,
   output logic signed [LITERAL_BITS-1:0]    cmd_lit
);
   import cprc_pkg::*;

   localparam int unsigned SW = $clog2(MAX_CLAUSES + 1);
   localparam int unsigned QW = (SW > INDEX_BITS) ? SW : INDEX_BITS;
   localparam logic signed [LITERAL_BITS-1:0] LIT_MIN = {1'b1, {(LITERAL_BITS-1){1'b0}}};

   logic [SW-1:0]                  stored_ff, stored_in;
   logic [LW-1:0]                  open_ff, open_in;
   logic signed [LITERAL_BITS-1:0] last_ff, last_in;
   logic                           full, too_long, bad_lit, bad_index;

   assign req_ready  = q_ready;
   assign q_push     = req_valid && q_ready;
   assign cmd_clause = CW'(stored_ff);
   assign cmd_pos    = open_ff;
   assign cmd_lit    = req_literal;

   assign full      = (stored_ff == SW'(MAX_CLAUSES));
   assign too_long  = (open_ff == LW'(MAX_LITERALS));
   assign bad_lit   = (req_literal == '0) || (req_literal <= last_ff);
   assign bad_index = (QW'(req_first_clause) >= QW'(stored_ff))
                   || (QW'(req_second_clause) >= QW'(stored_ff));

   always_comb begin
      cmd.kind   = CMD_NONE;
      cmd.status = ST_OK;
      cmd.first  = req_first_clause;
      cmd.second = req_second_clause;
      stored_in  = stored_ff;
      open_in    = open_ff;
      last_in    = last_ff;
      case (op_type'(req_op))
         OP_APPEND: begin
            if (full) begin
               cmd.status = ST_FULL;
            end else if (bad_lit) begin
               cmd.status = ST_BAD_LITERAL;
            end else if (too_long) begin
               cmd.status = ST_TOO_LONG;
            end else begin
               cmd.kind = CMD_LITERAL;
               open_in  = open_ff + LW'(1);
               last_in  = req_literal;
            end
         end
         OP_CLOSE: begin
            if (full) begin
               cmd.status = ST_FULL;
            end else begin
               cmd.kind  = CMD_LENGTH;
               stored_in = stored_ff + SW'(1);
               open_in   = '0;
               last_in   = LIT_MIN;
            end
         end
         OP_QUERY: begin
            if (bad_index) begin
               cmd.status = ST_BAD_INDEX;
            end else begin
               cmd.kind = CMD_QUERY;
            end
         end
         OP_CLEAR: begin
            stored_in = '0;
            open_in   = '0;
            last_in   = LIT_MIN;
         end
         default: begin
         end
      endcase
      cmd.count = COUNT_BITS'(stored_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         open_ff   <= '0;
         last_ff   <= LIT_MIN;
      end else if (q_push) begin
         stored_ff <= stored_in;
         open_ff   <= open_in;
         last_ff   <= last_in;
      end
   end

endmodule

FILE: hw/rtl/cprc_back.sv
module cprc_back #(
   parameter int unsigned MAX_CLAUSES  = cprc_pkg::MAX_CLAUSES_DEF,
   parameter int unsigned MAX_LITERALS = cprc_pkg::MAX_LITERALS_DEF,
   parameter int unsigned LITERAL_BITS = cprc_pkg::LITERAL_BITS_DEF,
   parameter int unsigned CW = $clog2(MAX_CLAUSES),
   parameter int unsigned LW = $clog2(MAX_LITERALS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  cprc_pkg::cmd_type                 h_cmd,
   input  logic [CW-1:0]                     h_clause,
   input  logic [LW-1:0]                     h_pos,
   input  logic signed [LITERAL_BITS-1:0]    h_lit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cprc_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic                              rsp_can_resolve,
   output logic [cprc_pkg::MERGE_BITS-1:0]   rsp_merge_count,
   output logic                              rsp_is_edge,
   output logic [cprc_pkg::COUNT_BITS-1:0]   rsp_clause_count
);
   import cprc_pkg::*;

   localparam int unsigned LB = LITERAL_BITS;
   localparam int unsigned MEM_DEPTH = MAX_CLAUSES * MAX_LITERALS;
   localparam int unsigned AW = $clog2(MEM_DEPTH);
   localparam logic signed [LW+1:0] ONE_S    = (LW+2)'(1);
   localparam logic signed [LW+1:0] TWO_S    = (LW+2)'(2);
   localparam logic signed [LW+1:0] LAST_POS = (LW+2)'(MAX_LITERALS - 1);

   function automatic logic [AW-1:0] lit_addr(input logic [CW-1:0] clause,
                                              input logic signed [LW+1:0] pos);
      logic [AW-1:0] offs;
      if (pos < 0) begin
         offs = '0;
      end else if (pos > LAST_POS) begin
         offs = AW'(MAX_LITERALS - 1);
      end else begin
         offs = AW'(pos);
      end
      return AW'(clause) * AW'(MAX_LITERALS) + offs;
   endfunction

   logic signed [LB-1:0] lit_mem [MEM_DEPTH];
   logic [LW-1:0]        len_mem [MAX_CLAUSES];

   back_state_type       state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [CW-1:0]        a_ff, a_in, b_ff, b_in;
   logic [LW-1:0]        la_ff, la_in, lb_ff, lb_in;
   logic [LW-1:0]        i_ff, i_in, k_ff, k_in, n_ff, n_in;
   logic                 res_ff, res_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic signed [LB-1:0] cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic signed [LB-1:0] rd_a_ff, rd_b_ff;
   logic [LW-1:0]        lrd_a_ff, lrd_b_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_res_ff, rsp_res_in;
   logic [MERGE_BITS-1:0] rsp_merge_ff, rsp_merge_in;
   logic                  rsp_edge_ff, rsp_edge_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                 out_free, walk_done, step_end, eq, lt, adv_a, adv_b;
   logic signed [LB:0]   va, vb, cb_ext;
   logic signed [LW+1:0] i_s, k_s, lb_s, lrd_s, ka_next, kb_next;
   logic signed [LW+1:0] ra_pos, rb_pos;
   logic                 lit_we, len_we;
   logic [AW-1:0]        ra_addr, rb_addr, wa_addr;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_can_resolve  = rsp_res_ff;
   assign rsp_merge_count  = rsp_merge_ff;
   assign rsp_is_edge      = rsp_edge_ff;
   assign rsp_clause_count = rsp_count_ff;

   // compare of the current pair of literals
   assign va        = (LB+1)'(cur_a_ff);
   assign cb_ext    = (LB+1)'(cur_b_ff);
   assign vb        = (phase_ff == PH_RESOLVE) ? -cb_ext : cb_ext;
   assign eq        = (va == vb);
   assign lt        = (va < vb);
   assign walk_done = (i_ff >= la_ff) || (k_ff >= lb_ff);
   assign step_end  = walk_done || ((phase_ff == PH_RESOLVE) && eq);
   assign adv_a     = eq || lt;
   assign adv_b     = (phase_ff == PH_MERGE) ? !lt : !(eq || lt);

   assign i_s     = signed'((LW+2)'(i_ff));
   assign k_s     = signed'((LW+2)'(k_ff));
   assign lb_s    = signed'((LW+2)'(lb_ff));
   assign lrd_s   = signed'((LW+2)'(lrd_b_ff));
   assign ka_next = adv_a ? i_s + TWO_S : i_s + ONE_S;
   assign kb_next = adv_b ? k_s + TWO_S : k_s + ONE_S;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && (h_cmd.kind == CMD_QUERY)) begin
               state_in = BK_LENGTH;
            end
         end
         BK_LENGTH: state_in = BK_PRIME;
         BK_PRIME:  state_in = BK_STEP;
         BK_STEP: begin
            if (step_end) begin
               state_in = (phase_ff == PH_MERGE) ? BK_DONE : BK_PRIME;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      lit_we        = 1'b0;
      len_we        = 1'b0;
      phase_in      = phase_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      la_in         = la_ff;
      lb_in         = lb_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      n_in          = n_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      cur_a_in      = cur_a_ff;
      cur_b_in      = cur_b_ff;
      ra_pos        = '0;
      rb_pos        = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_merge_in  = rsp_merge_ff;
      rsp_edge_in   = rsp_edge_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (h_cmd.kind == CMD_QUERY) begin
                  q_pop  = 1'b1;
                  a_in   = CW'(h_cmd.first);
                  b_in   = CW'(h_cmd.second);
                  cnt_in = h_cmd.count;
               end else if (out_free) begin
                  q_pop         = 1'b1;
                  lit_we        = (h_cmd.kind == CMD_LITERAL);
                  len_we        = (h_cmd.kind == CMD_LENGTH);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = h_cmd.status;
                  rsp_res_in    = 1'b0;
                  rsp_merge_in  = '0;
                  rsp_edge_in   = 1'b0;
                  rsp_count_in  = h_cmd.count;
               end
            end
         end
         BK_LENGTH: begin
            la_in    = lrd_a_ff;
            lb_in    = lrd_b_ff;
            i_in     = '0;
            k_in     = '0;
            n_in     = '0;
            res_in   = 1'b0;
            phase_in = PH_RESOLVE;
            ra_pos   = '0;
            rb_pos   = lrd_s - ONE_S;
         end
         BK_PRIME: begin
            cur_a_in = rd_a_ff;
            cur_b_in = rd_b_ff;
            ra_pos   = ONE_S;
            rb_pos   = (phase_ff == PH_RESOLVE) ? lb_s - TWO_S : ONE_S;
         end
         BK_STEP: begin
            if (step_end) begin
               if (!walk_done) begin
                  res_in = 1'b1;
               end
               phase_in = PH_MERGE;
               i_in     = '0;
               k_in     = '0;
               ra_pos   = '0;
               rb_pos   = '0;
            end else begin
               i_in     = i_ff + LW'(adv_a);
               k_in     = k_ff + LW'(adv_b);
               n_in     = n_ff + LW'((phase_ff == PH_MERGE) && eq);
               cur_a_in = adv_a ? rd_a_ff : cur_a_ff;
               cur_b_in = adv_b ? rd_b_ff : cur_b_ff;
               ra_pos   = ka_next;
               rb_pos   = (phase_ff == PH_RESOLVE) ? lb_s - ONE_S - kb_next : kb_next;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_res_in    = res_ff;
               rsp_merge_in  = MERGE_BITS'(n_ff);
               rsp_edge_in   = res_ff && (n_ff != '0);
               rsp_count_in  = cnt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign ra_addr = lit_addr(a_ff, ra_pos);
   assign rb_addr = lit_addr(b_ff, rb_pos);
   assign wa_addr = lit_addr(h_clause, signed'((LW+2)'(h_pos)));

   always_ff @(posedge clock) begin
      if (lit_we) begin
         lit_mem[wa_addr] <= h_lit;
      end
      rd_a_ff <= lit_mem[ra_addr];
      rd_b_ff <= lit_mem[rb_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[h_clause] <= h_pos;
      end
      lrd_a_ff <= len_mem[CW'(h_cmd.first)];
      lrd_b_ff <= len_mem[CW'(h_cmd.second)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      la_ff         <= la_in;
      lb_ff         <= lb_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      n_ff          <= n_in;
      res_ff        <= res_in;
      cnt_ff        <= cnt_in;
      cur_a_ff      <= cur_a_in;
      cur_b_ff      <= cur_b_in;
      rsp_status_ff <= rsp_status_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_merge_ff  <= rsp_merge_in;
      rsp_edge_ff   <= rsp_edge_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

FILE: hw/rtl/clause_pair_merge_resolve_check.sv
// clause table with pair resolution and merge check
// req channel (req_valid/req_ready) takes one request per handshake: append a
// literal, close the open clause, query a pair of stored clauses, or clear.
// rsp channel (rsp_valid/rsp_ready) returns exactly one result per request,
// in request order, held stable until taken.
// a front stage checks each request against the table state in the cycle it
// is accepted and posts a command into a two-entry queue; a back stage owns
// the literal and length memories and carries the commands out.
// the back answers appends, closes, clears and rejected requests from its
// idle state. a query makes one length read, then two sorted walks over the
// clause pair (resolve, then merge), each at one literal pair per cycle on
// the two read ports of the literal memory and each after a priming step,
// and then hands off its result.
// while the receiver stalls, the front keeps accepting until the queue is
// full; the back finishes a query walk and then waits on the result register.
// reset empties the queue and the table (clause count, open clause); memory
// contents are left as they are and never used before being rewritten.
module clause_pair_merge_resolve_check #(
   parameter int unsigned MAX_CLAUSES  = cprc_pkg::MAX_CLAUSES_DEF,
   parameter int unsigned MAX_LITERALS = cprc_pkg::MAX_LITERALS_DEF,
   parameter int unsigned LITERAL_BITS = cprc_pkg::LITERAL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_op,
   input  logic signed [LITERAL_BITS-1:0]    req_literal,
   input  logic [cprc_pkg::INDEX_BITS-1:0]   req_first_clause,
   input  logic [cprc_pkg::INDEX_BITS-1:0]   req_second_clause,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cprc_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic                              rsp_can_resolve,
   output logic [cprc_pkg::MERGE_BITS-1:0]   rsp_merge_count,
   output logic                              rsp_is_edge,
   output logic [cprc_pkg::COUNT_BITS-1:0]   rsp_clause_count
);
   import cprc_pkg::*;

   localparam int unsigned CW = $clog2(MAX_CLAUSES);
   localparam int unsigned LW = $clog2(MAX_LITERALS + 1);
   localparam int unsigned QWIDTH = $bits(cmd_type) + CW + LW + LITERAL_BITS;

   cmd_type                        f_cmd, h_cmd;
   logic [CW-1:0]                  f_clause, h_clause;
   logic [LW-1:0]                  f_pos, h_pos;
   logic signed [LITERAL_BITS-1:0] f_lit, h_lit;
   logic                           q_push, q_ready, q_pop, q_valid;
   logic [QWIDTH-1:0]              q_in, q_out;

   cprc_front #(
      .MAX_CLAUSES  (MAX_CLAUSES),
      .MAX_LITERALS (MAX_LITERALS),
      .LITERAL_BITS (LITERAL_BITS),
      .CW           (CW),
      .LW           (LW)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_literal       (req_literal),
      .req_first_clause  (req_first_clause),
      .req_second_clause (req_second_clause),
      .q_ready           (q_ready),
      .q_push            (q_push),
      .cmd               (f_cmd),
      .cmd_clause        (f_clause),
      .cmd_pos           (f_pos),
      .cmd_lit           (f_lit)
   );

   assign q_in = {f_cmd, f_clause, f_pos, f_lit};

   cprc_queue #(
      .WIDTH (QWIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out)
   );

   assign {h_cmd, h_clause, h_pos, h_lit} = q_out;

   cprc_back #(
      .MAX_CLAUSES  (MAX_CLAUSES),
      .MAX_LITERALS (MAX_LITERALS),
      .LITERAL_BITS (LITERAL_BITS),
      .CW           (CW),
      .LW           (LW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .h_cmd            (h_cmd),
      .h_clause         (h_clause),
      .h_pos            (h_pos),
      .h_lit            (h_lit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_can_resolve  (rsp_can_resolve),
      .rsp_merge_count  (rsp_merge_count),
      .rsp_is_edge      (rsp_is_edge),
      .rsp_clause_count (rsp_clause_count)
   );

endmodule
